### rtl/bm25_pkg.sv
// ----------------------------------------------------------------------------
// BM25 posting scorer package
// Field widths, scoring constants and derived widths shared by the block.
// ----------------------------------------------------------------------------
package bm25_pkg;

    localparam int TF_W          = 16;
    localparam int DLEN_W        = 20;
    localparam int IDF_W         = 24;
    localparam int SCORE_W       = 24;
    localparam int IDF_FRAC_BITS = 16;

    localparam int DEF_SCORE_FRAC_BITS = 16;

    // score = idf * 780f / (260f + 130 + 3*dlen)
    localparam int K_NUM  = 780;
    localparam int K_TF   = 260;
    localparam int K_BIAS = 130;
    localparam int K_DL   = 3;

    localparam int PROD_W     = IDF_W + TF_W;
    localparam int SCALED_W   = PROD_W + 10;
    localparam int DEN_BASE_W = 25;

    localparam int Q_DEPTH = 2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

endpackage

### rtl/bm25_posting_scorer.sv
// ----------------------------------------------------------------------------
// BM25 posting scorer
// Scores postings of an inverted list and tracks the list maximum.
// ----------------------------------------------------------------------------
// Usage: write the list idf (unsigned Q8.16) on the cfg channel while the
// block is idle; the port is always ready. Postings enter on the in channel
// (valid/stall), one beat per posting; results leave on the out channel
// (valid/stall), one beat per posting, in order.
// Each result carries the saturated Q8.16 score, the list maximum so far and
// the last flag; after the last posting the maximum restarts from zero.
// The serial divider in the back end produces one quotient bit per cycle
// and works on one posting at a time; a posting whose score saturates
// skips the division. The front end and a two-entry queue take further
// postings meanwhile.
// A stalled result is held in the output register; the divider then waits,
// the queue fills and the input stall rises.
// Reset clears the idf, the running maximum and all valid state.
// ----------------------------------------------------------------------------
module bm25_posting_scorer
    import bm25_pkg::*;
#(
    parameter int SCORE_FRAC_BITS = DEF_SCORE_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDF_W-1:0]   i_cfg_idf_weight,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [TF_W-1:0]    i_term_freq,
    input  logic [DLEN_W-1:0]  i_doc_length,
    input  logic               i_last_posting,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SCORE_W-1:0] o_score,
    output logic [SCORE_W-1:0] o_list_max,
    output logic               o_last
);

    localparam int UP    = (SCORE_FRAC_BITS >= IDF_FRAC_BITS) ?
                           SCORE_FRAC_BITS - IDF_FRAC_BITS : 0;
    localparam int DN    = (SCORE_FRAC_BITS < IDF_FRAC_BITS) ?
                           IDF_FRAC_BITS - SCORE_FRAC_BITS : 0;
    localparam int NUM_W = SCALED_W + UP;
    localparam int DEN_W = DEN_BASE_W + DN;
    localparam int ENT_W = NUM_W + DEN_W + 1;

    logic [IDF_W-1:0] r_idf_weight;
    logic             push;
    logic             full;
    logic             q_valid;
    logic             q_pop;
    logic [NUM_W-1:0] f_num;
    logic [DEN_W-1:0] f_den;
    logic             f_last;
    logic [ENT_W-1:0] q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idf_weight <= '0;
        end else if (i_cfg_valid) begin
            r_idf_weight <= i_cfg_idf_weight;
        end
    end

    bm25_front #(
        .UP    (UP),
        .DN    (DN),
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_term_freq    (i_term_freq),
        .i_doc_length   (i_doc_length),
        .i_last_posting (i_last_posting),
        .i_idf_weight   (r_idf_weight),
        .i_full         (full),
        .o_push         (push),
        .o_num          (f_num),
        .o_den          (f_den),
        .o_last         (f_last)
    );

    bm25_queue #(
        .W (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_last, f_den, f_num}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    bm25_back #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_num       (q_data[NUM_W-1:0]),
        .i_den       (q_data[NUM_W+DEN_W-1:NUM_W]),
        .i_last      (q_data[ENT_W-1]),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_score     (o_score),
        .o_list_max  (o_list_max),
        .o_last      (o_last)
    );

endmodule

### rtl/bm25_front.sv
// ----------------------------------------------------------------------------
// BM25 front end
// Accepts postings, forms numerator and denominator and pushes them on.
// ----------------------------------------------------------------------------
module bm25_front
    import bm25_pkg::*;
#(
    parameter int UP    = 0,
    parameter int DN    = 0,
    parameter int NUM_W = SCALED_W + UP,
    parameter int DEN_W = DEN_BASE_W + DN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [TF_W-1:0]   i_term_freq,
    input  logic [DLEN_W-1:0] i_doc_length,
    input  logic              i_last_posting,
    input  logic [IDF_W-1:0]  i_idf_weight,
    input  logic              i_full,
    output logic              o_push,
    output logic [NUM_W-1:0]  o_num,
    output logic [DEN_W-1:0]  o_den,
    output logic              o_last
);

    logic                  r_f_valid;
    logic                  n_f_valid;
    logic [PROD_W-1:0]     r_prod;
    logic [DEN_BASE_W-1:0] r_den;
    logic                  r_last;
    logic                  load;
    logic [SCALED_W-1:0]   scaled;
    logic [DEN_BASE_W-1:0] den_new;

    assign o_in_stall = r_f_valid && i_full;
    assign load       = i_in_valid && !o_in_stall;
    assign o_push     = r_f_valid && !i_full;

    assign den_new = DEN_BASE_W'(i_term_freq) * DEN_BASE_W'(K_TF)
                   + DEN_BASE_W'(K_BIAS)
                   + DEN_BASE_W'(i_doc_length) * DEN_BASE_W'(K_DL);

    assign scaled = SCALED_W'(r_prod) * SCALED_W'(K_NUM);
    assign o_num  = NUM_W'(scaled) << UP;
    assign o_den  = DEN_W'(r_den) << DN;
    assign o_last = r_last;

    always_comb begin
        n_f_valid = r_f_valid;
        if (load) begin
            n_f_valid = 1'b1;
        end else if (o_push) begin
            n_f_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= n_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_prod <= PROD_W'(i_idf_weight) * PROD_W'(i_term_freq);
            r_den  <= den_new;
            r_last <= i_last_posting;
        end
    end

endmodule

### rtl/bm25_queue.sv
// ----------------------------------------------------------------------------
// BM25 work queue
// Short queue of prepared divisions between front end and divider.
// ----------------------------------------------------------------------------
module bm25_queue
    import bm25_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [W-1:0]     r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/bm25_back.sv
// ----------------------------------------------------------------------------
// BM25 back end
// Serial restoring divider with saturation, running maximum and output beat.
// ----------------------------------------------------------------------------
module bm25_back
    import bm25_pkg::*;
#(
    parameter int NUM_W = SCALED_W,
    parameter int DEN_W = DEN_BASE_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [SCORE_W-1:0] o_score,
    output logic [SCORE_W-1:0] o_list_max,
    output logic               o_last
);

    localparam int HI_W  = NUM_W - SCORE_W;
    localparam int REM_W = (HI_W > DEN_W + 1) ? HI_W : DEN_W + 1;
    localparam int CNT_W = $clog2(SCORE_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]         r_state;
    logic [REM_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [SCORE_W-1:0] r_lo;
    logic [SCORE_W-1:0] r_quo;
    logic               r_last_q;
    logic [CNT_W-1:0]   r_cnt;
    logic [SCORE_W-1:0] r_max;
    logic               r_out_valid;
    logic [SCORE_W-1:0] r_score;
    logic [SCORE_W-1:0] r_list_max;
    logic               r_last;

    logic [REM_W-1:0]   hi;
    logic               ovf;
    logic [REM_W-1:0]   shifted;
    logic               ge;
    logic               can_load;
    logic [SCORE_W-1:0] max_new;

    assign hi       = REM_W'(i_num[NUM_W-1:SCORE_W]);
    assign ovf      = hi >= REM_W'(i_den);
    assign shifted  = {r_rem[REM_W-2:0], r_lo[SCORE_W-1]};
    assign ge       = shifted >= REM_W'(r_den);
    assign can_load = !r_out_valid || !i_out_stall;
    assign max_new  = (r_quo > r_max) ? r_quo : r_max;
    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;

    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;
    assign o_list_max  = r_list_max;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_max       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if ((r_state == ST_OUT) && can_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_cnt   <= '0;
                        r_state <= ovf ? ST_OUT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SCORE_W - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (can_load) begin
                        r_max   <= r_last_q ? '0 : max_new;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rem    <= hi;
            r_den    <= i_den;
            r_lo     <= i_num[SCORE_W-1:0];
            r_last_q <= i_last;
            r_quo    <= SCORE_MAX;
        end else if (r_state == ST_DIV) begin
            r_rem <= ge ? (shifted - REM_W'(r_den)) : shifted;
            r_lo  <= {r_lo[SCORE_W-2:0], 1'b0};
            r_quo <= {r_quo[SCORE_W-2:0], ge};
        end
        if ((r_state == ST_OUT) && can_load) begin
            r_score    <= r_quo;
            r_list_max <= max_new;
            r_last     <= r_last_q;
        end
    end

    a_max_covers_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_list_max >= r_score))
        else $error("list maximum below score");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < REM_W'(r_den)))
        else $error("partial remainder not below divisor");

    a_out_held_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_score)))
        else $error("stalled result lost");

    a_max_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && can_load && r_last_q) |=> (r_max == '0))
        else $error("running maximum not cleared at end of list");

endmodule

### bench/bm25_posting_scorer_tb.sv
// ----------------------------------------------------------------------------
// BM25 posting scorer testbench
// Drives postings in random bursts against a randomly stalling receiver,
// predicts each score and list maximum in the bench itself, and compares
// every result beat field by field. The idf register is rewritten between
// phases while the block is idle, zero and full scale among the values.
// ----------------------------------------------------------------------------
module bm25_posting_scorer_tb;
    import bm25_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCORE_FRAC  = DEF_SCORE_FRAC_BITS;
    localparam int UP_SHIFT    = (SCORE_FRAC >= IDF_FRAC_BITS) ?
                                 (SCORE_FRAC - IDF_FRAC_BITS) % 16 : 0;
    localparam int DOWN_SHIFT  = (SCORE_FRAC < IDF_FRAC_BITS) ?
                                 (IDF_FRAC_BITS - SCORE_FRAC) % 16 : 0;
    localparam int NUM_GAIN    = 780;
    localparam int TF_GAIN     = 260;
    localparam int LEN_BIAS    = 130;
    localparam int LEN_GAIN    = 3;
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 75;
    localparam int RAND_PHASES = 10;

    typedef struct packed {
        logic [TF_W-1:0]   term_freq;
        logic [DLEN_W-1:0] doc_length;
        logic              last_posting;
    } posting_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [SCORE_W-1:0] list_max;
        logic               last;
    } score_beat_t;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_LIGHT,
        PACE_HEAVY,
        PACE_PERIODIC
    } pace_mode_t;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_cfg_valid      = 1'b0;
    logic               o_cfg_ready;
    logic [IDF_W-1:0]   i_cfg_idf_weight = '0;
    logic               i_in_valid       = 1'b0;
    logic               o_in_stall;
    logic [TF_W-1:0]    i_term_freq      = '0;
    logic [DLEN_W-1:0]  i_doc_length     = '0;
    logic               i_last_posting   = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall      = 1'b0;
    logic [SCORE_W-1:0] o_score;
    logic [SCORE_W-1:0] o_list_max;
    logic               o_last;

    posting_t           posting_q[$];
    score_beat_t        expected_scores[$];
    logic [IDF_W-1:0]   idf_model = '0;
    logic [SCORE_W-1:0] list_peak = '0;
    int                 mismatch_count = 0;
    int                 hold_requests  = 0;
    int                 holds_done     = 0;

    bm25_posting_scorer #(
        .SCORE_FRAC_BITS(SCORE_FRAC)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_idf_weight(i_cfg_idf_weight),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_term_freq     (i_term_freq),
        .i_doc_length    (i_doc_length),
        .i_last_posting  (i_last_posting),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_score         (o_score),
        .o_list_max      (o_list_max),
        .o_last          (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [SCORE_W-1:0] bm25_term_score(input logic [TF_W-1:0] f,
                                                           input logic [DLEN_W-1:0] dlen);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quot;
        num  = (64'(idf_model) * 64'(NUM_GAIN) * 64'(f)) << UP_SHIFT;
        den  = (64'(TF_GAIN) * 64'(f) + 64'(LEN_BIAS) + 64'(LEN_GAIN) * 64'(dlen))
               << DOWN_SHIFT;
        quot = num / den;
        return (quot > 64'(SCORE_MAX)) ? SCORE_MAX : quot[SCORE_W-1:0];
    endfunction

    // Driver: bursts of random length, random gaps between them
    always @(posedge i_clk) begin : drive_postings
        int          burst_left;
        int          gap_left;
        logic        presented;
        logic        next_valid;
        score_beat_t beat;
        if (!i_rst_n) begin
            burst_left = 0;
            gap_left   = 0;
            i_in_valid <= 1'b0;
        end else begin
            presented = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                beat.score    = bm25_term_score(i_term_freq, i_doc_length);
                beat.list_max = (beat.score > list_peak) ? beat.score : list_peak;
                beat.last     = i_last_posting;
                expected_scores.insert(expected_scores.size(), beat);
                list_peak = i_last_posting ? '0 : beat.list_max;
                void'(posting_q.pop_front());
                presented = 1'b0;
            end
            if (!presented) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (posting_q.size() > 0) begin
                    next_valid = 1'b1;
                    i_term_freq    <= posting_q[0].term_freq;
                    i_doc_length   <= posting_q[0].doc_length;
                    i_last_posting <= posting_q[0].last_posting;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 7))
                            0, 1, 2: gap_left = 0;
                            7:       gap_left = $urandom_range(20, 40);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end
                i_in_valid <= next_valid;
            end
        end
    end

    // Receiver: own stall pattern, plus long hold-offs on request
    always @(posedge i_clk) begin : pace_results
        int         hold_left;
        int         mode_left;
        int         phase_cnt;
        pace_mode_t mode;
        logic       stall_next;
        if (!i_rst_n) begin
            hold_left = 0;
            mode_left = 0;
            phase_cnt = 0;
            mode      = PACE_FREE;
            i_out_stall <= 1'b0;
        end else begin
            phase_cnt++;
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (holds_done < hold_requests) begin
                holds_done++;
                hold_left  = LONG_HOLD - 1;
                stall_next = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = pace_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end else begin
                    mode_left--;
                end
                case (mode)
                    PACE_FREE:  stall_next = 1'b0;
                    PACE_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                    PACE_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                    default:    stall_next = ((phase_cnt % 7) < 3);
                endcase
            end
            i_out_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin : check_results
        score_beat_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_scores.size() == 0) begin
                $error("result beat with no posting pending: score %h", o_score);
                mismatch_count++;
            end else begin
                want = expected_scores.pop_front();
                if (o_score !== want.score) begin
                    $error("score: expected %h, got %h", want.score, o_score);
                    mismatch_count++;
                end
                if (o_list_max !== want.list_max) begin
                    $error("list_max: expected %h, got %h", want.list_max, o_list_max);
                    mismatch_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_idf(input logic [IDF_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_idf_weight <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        idf_model = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (posting_q.size() != 0 || i_in_valid || expected_scores.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_posting(input int f, input int dlen, input bit last);
        posting_t p;
        p.term_freq    = f[TF_W-1:0];
        p.doc_length   = dlen[DLEN_W-1:0];
        p.last_posting = last;
        posting_q.insert(posting_q.size(), p);
    endtask

    function automatic int random_freq();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 65535);
            1:       return $urandom_range(1, 1000);
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    function automatic int random_length();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 1048575);
            default: return $urandom_range(0, 2000);
        endcase
    endfunction

    // Push one list; now and then a broken one with random end flags
    task automatic add_list(inout int pushed);
        int len;
        bit broken;
        len    = $urandom_range(1, 12);
        broken = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++)
            add_posting(random_freq(), random_length(),
                        broken ? bit'($urandom_range(0, 1)) : (i == len - 1));
        pushed += len;
    endtask

    function automatic logic [IDF_W-1:0] random_idf(input int phase);
        case (phase % 5)
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h000001;
            3:       return IDF_W'($urandom_range(24'h008000, 24'h080000));
            default: return IDF_W'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    initial begin : stimulus
        int pushed;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idf still at its reset value
        add_posting(1, 0, 1'b0);
        add_posting(65535, 1048575, 1'b0);
        add_posting(0, 0, 1'b1);
        wait_drained();

        // full-scale idf: saturation, zero frequency, field extremes
        write_idf(24'hFFFFFF);
        add_posting(1, 0, 1'b0);
        add_posting(65535, 0, 1'b0);
        add_posting(65535, 1048575, 1'b0);
        add_posting(1, 1048575, 1'b0);
        add_posting(0, 0, 1'b0);
        add_posting(0, 1048575, 1'b1);
        add_posting(16'h5555, 20'hAAAAA, 1'b0);
        add_posting(16'hAAAA, 20'h55555, 1'b1);
        add_posting(2, 130, 1'b1);
        add_posting(3, 5000, 1'b1);
        wait_drained();

        write_idf(24'h010000);
        add_posting(1, 0, 1'b0);
        add_posting(1, 130, 1'b0);
        add_posting(100, 130, 1'b0);
        add_posting(65535, 0, 1'b0);
        add_posting(0, 0, 1'b1);
        add_posting(7, 20, 1'b1);
        add_posting(1, 1048575, 1'b1);
        wait_drained();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            write_idf(random_idf(phase));
            pushed = 0;
            while (pushed < PHASE_ITEMS / 2)
                add_list(pushed);
            if (phase == 3 || phase == 7)
                hold_requests++;
            if (phase % 3 == 1)
                wait_drained();
            while (pushed < PHASE_ITEMS)
                add_list(pushed);
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_scores.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/bm25_pkg.sv
rtl/bm25_front.sv
rtl/bm25_queue.sv
rtl/bm25_back.sv
rtl/bm25_posting_scorer.sv
bench/bm25_posting_scorer_tb.sv
